/* rtl/fhsa_pkg.sv */
// ----------------------------------------------------------------------------
// fhsa_pkg
// Shared types and constants of the flame histogram splat accumulator.
// ----------------------------------------------------------------------------
package fhsa_pkg;

  // image store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int COUNT_BITS = 32;

  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS = $clog2(DEPTH);

  // field widths fixed by the interface
  localparam int POS_BITS   = 12;
  localparam int CHAN_BITS  = 8;
  localparam int COLOR_BITS = 3 * CHAN_BITS;
  localparam int HIT_BITS   = 32;

  // configuration registers
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 10;
  localparam int WARM_BITS     = 8;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = HEIGHT_BITS'(512);
  localparam logic [WARM_BITS-1:0]   WARM_RST   = WARM_BITS'(21);

  // compare width: holds any nonnegative coordinate and either image limit
  localparam int MAX_WH  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAX_DIM = (MAX_WH > (1 << (POS_BITS - 1))) ? MAX_WH : (1 << (POS_BITS - 1));
  localparam int CMP_BITS = $clog2(MAX_DIM + 1);

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_SPLAT = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WARMUP = 2'd2
  } cfg_idx_e;

  // one classified item on its way to the store
  typedef struct packed {
    func_e                  func;
    logic                   in_image;
    logic [ADDR_BITS-1:0]   addr;
    logic [CHAN_BITS-1:0]   red;
    logic [CHAN_BITS-1:0]   green;
    logic [CHAN_BITS-1:0]   blue;
  } item_t;

endpackage

/* rtl/fhsa_front.sv */
// ----------------------------------------------------------------------------
// fhsa_front
// Holds the configuration and the warm-up count, range-checks each item and
// queues the ones that touch the store.
// ----------------------------------------------------------------------------
module fhsa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fhsa_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [fhsa_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [fhsa_pkg::POS_BITS-1:0] pos_x_i,
  input  logic signed [fhsa_pkg::POS_BITS-1:0] pos_y_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0] color_red_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0] color_green_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0] color_blue_i,
  input  logic                          busy_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output fhsa_pkg::item_t               q_item_o
);
  import fhsa_pkg::*;

  logic [WIDTH_BITS-1:0]  width_q, width_d;
  logic [HEIGHT_BITS-1:0] height_q, height_d;
  logic [WARM_BITS-1:0]   warm_q, warm_d;
  logic [WARM_BITS-1:0]   seen_q, seen_d;

  logic [CMP_BITS-1:0] eff_w, eff_h, x_u, y_u;
  logic                in_image, accept, in_warmup;
  func_e               func;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i | busy_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign func        = func_e'(func_i);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    warm_d   = warm_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_d  = cfg_data_i[WIDTH_BITS-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[HEIGHT_BITS-1:0];
        CFG_WARMUP: warm_d   = cfg_data_i[WARM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective image size is clipped to the store
  assign eff_w = (CMP_BITS'(width_q) < CMP_BITS'(MAX_WIDTH)) ? CMP_BITS'(width_q)
                                                           : CMP_BITS'(MAX_WIDTH);
  assign eff_h = (CMP_BITS'(height_q) < CMP_BITS'(MAX_HEIGHT)) ? CMP_BITS'(height_q)
                                                             : CMP_BITS'(MAX_HEIGHT);
  assign x_u = CMP_BITS'(pos_x_i[POS_BITS-2:0]);
  assign y_u = CMP_BITS'(pos_y_i[POS_BITS-2:0]);

  assign in_image = ~pos_x_i[POS_BITS-1] & ~pos_y_i[POS_BITS-1]
                  & (x_u < eff_w) & (y_u < eff_h);

  assign in_warmup = seen_q < warm_q;

  always_comb begin
    seen_d = seen_q;
    if (accept && func == FUNC_SPLAT && in_warmup) begin
      seen_d = seen_q + WARM_BITS'(1);
    end
  end

  always_comb begin
    q_item_o.func     = func;
    q_item_o.in_image = in_image;
    q_item_o.addr     = in_image ? ADDR_BITS'(y_u) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(x_u)
                                 : '0;
    q_item_o.red      = color_red_i;
    q_item_o.green    = color_green_i;
    q_item_o.blue     = color_blue_i;
  end

  // warm-up and out-of-range splats never reach the store
  assign q_push_o = accept & ((func == FUNC_READ) | (in_image & ~in_warmup));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      warm_q   <= WARM_RST;
      seen_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      warm_q   <= warm_d;
      seen_q   <= seen_d;
    end
  end

endmodule

/* rtl/fhsa_queue.sv */
// ----------------------------------------------------------------------------
// fhsa_queue
// Short first-in first-out queue of classified items between front and engine.
// ----------------------------------------------------------------------------
module fhsa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fhsa_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output fhsa_pkg::item_t pop_item_o,
  output logic            empty_o
);
  import fhsa_pkg::*;

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_BITS-1:0] next_ptr(logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  assign full_o     = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/fhsa_engine.sv */
// ----------------------------------------------------------------------------
// fhsa_engine
// Clears the color and count stores after reset, then runs each queued item
// as a read of the pixel followed by an update write or a result transfer.
// ----------------------------------------------------------------------------
module fhsa_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  output logic                           busy_o,
  input  logic                           q_empty_i,
  input  fhsa_pkg::item_t                q_item_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fhsa_pkg::CHAN_BITS-1:0] pixel_red_o,
  output logic [fhsa_pkg::CHAN_BITS-1:0] pixel_green_o,
  output logic [fhsa_pkg::CHAN_BITS-1:0] pixel_blue_o,
  output logic [fhsa_pkg::HIT_BITS-1:0]  hit_count_o,
  output logic [fhsa_pkg::HIT_BITS-1:0]  peak_count_o,
  output logic                           in_range_o
);
  import fhsa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e state_q, state_d;

  logic [COLOR_BITS-1:0] color_mem [DEPTH];
  logic [COUNT_BITS-1:0] count_mem [DEPTH];

  logic [ADDR_BITS-1:0]  clr_cnt_q, clr_cnt_d;
  item_t                 cur_q, cur_d;
  logic [COLOR_BITS-1:0] rd_color_q;
  logic [COUNT_BITS-1:0] rd_count_q;
  logic [COUNT_BITS-1:0] max_q, max_d;

  logic                  out_valid_q, out_valid_d;
  logic [CHAN_BITS-1:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [COUNT_BITS-1:0] hit_q, hit_d;
  logic [COUNT_BITS-1:0] peak_q, peak_d;
  logic                  range_q, range_d;

  logic                  we;
  logic [ADDR_BITS-1:0]  waddr;
  logic [COLOR_BITS-1:0] wcolor;
  logic [COUNT_BITS-1:0] wcount;
  logic [CHAN_BITS:0]    sum_r, sum_g, sum_b;
  logic [COUNT_BITS-1:0] new_count;
  logic                  out_free, load_out;

  assign busy_o   = state_q == ST_CLEAR;
  assign q_pop_o  = (state_q == ST_IDLE) & ~q_empty_i;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // per-channel average rounds down
  assign sum_r = {1'b0, rd_color_q[3*CHAN_BITS-1:2*CHAN_BITS]} + {1'b0, cur_q.red};
  assign sum_g = {1'b0, rd_color_q[2*CHAN_BITS-1:CHAN_BITS]} + {1'b0, cur_q.green};
  assign sum_b = {1'b0, rd_color_q[CHAN_BITS-1:0]} + {1'b0, cur_q.blue};
  assign new_count = (&rd_count_q) ? rd_count_q : rd_count_q + COUNT_BITS'(1);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    max_d       = max_q;
    out_valid_d = out_valid_q & out_stall_i;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    hit_d       = hit_q;
    peak_d      = peak_q;
    range_d     = range_q;
    we          = 1'b0;
    waddr       = cur_q.addr;
    wcolor      = {sum_r[CHAN_BITS:1], sum_g[CHAN_BITS:1], sum_b[CHAN_BITS:1]};
    wcount      = new_count;
    load_out    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wcolor    = '0;
        wcount    = '0;
        clr_cnt_d = clr_cnt_q + ADDR_BITS'(1);
        if (clr_cnt_q == ADDR_BITS'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          cur_d   = q_item_i;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cur_q.func == FUNC_SPLAT) begin
          we      = 1'b1;
          state_d = ST_IDLE;
          if (new_count > max_q) begin
            max_d = new_count;
          end
        end else if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          red_d       = cur_q.in_image ? rd_color_q[3*CHAN_BITS-1:2*CHAN_BITS] : '0;
          green_d     = cur_q.in_image ? rd_color_q[2*CHAN_BITS-1:CHAN_BITS] : '0;
          blue_d      = cur_q.in_image ? rd_color_q[CHAN_BITS-1:0] : '0;
          hit_d       = cur_q.in_image ? rd_count_q : '0;
          peak_d      = max_q;
          range_d     = cur_q.in_image;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // single read port and single write port; read data registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      color_mem[waddr] <= wcolor;
      count_mem[waddr] <= wcount;
    end
    if (q_pop_o) begin
      rd_color_q <= color_mem[q_item_i.addr];
      rd_count_q <= count_mem[q_item_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cur_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      hit_q       <= '0;
      peak_q      <= '0;
      range_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_q       <= cur_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      hit_q       <= hit_d;
      peak_q      <= peak_d;
      range_q     <= range_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = red_q;
  assign pixel_green_o = green_q;
  assign pixel_blue_o  = blue_q;
  assign hit_count_o   = HIT_BITS'(hit_q);
  assign peak_count_o  = HIT_BITS'(peak_q);
  assign in_range_o    = range_q;

  a_no_pop_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !q_pop_o)
    else $error("queue popped during store clear");

  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_q >= $past(max_q))
    else $error("peak count decreased");

  a_load_only_for_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == ST_LOOK) && (cur_q.func == FUNC_READ) && out_free)
    else $error("result loaded outside a read");

  a_out_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !range_q) |-> (hit_q == '0) && (red_q == '0))
    else $error("out-of-range result carries pixel data");

endmodule

/* rtl/flame_histogram_splat_accumulator_top.sv */
// ----------------------------------------------------------------------------
// flame_histogram_splat_accumulator_top
// Per-pixel color averaging and hit counting of plotted flame points.
// ----------------------------------------------------------------------------
// throughput: the engine takes a queued item (read, or splat that reaches the store) only
//   after it has read the pixel and written or sent the result of the last one; warm-up and
//   out-of-range splats are taken one per cycle while the queue has room and no clear runs
// result path: queue, registered store read, result register; out_stall_i holds the engine
// reset: stores are swept to zero over all MAX_WIDTH*MAX_HEIGHT addresses (524288),
//   in_stall_o is high meanwhile; configuration writes are taken throughout
module flame_histogram_splat_accumulator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fhsa_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [fhsa_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic signed [fhsa_pkg::POS_BITS-1:0] pos_x_i,
  input  logic signed [fhsa_pkg::POS_BITS-1:0] pos_y_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0]      color_red_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0]      color_green_i,
  input  logic [fhsa_pkg::CHAN_BITS-1:0]      color_blue_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fhsa_pkg::CHAN_BITS-1:0]      pixel_red_o,
  output logic [fhsa_pkg::CHAN_BITS-1:0]      pixel_green_o,
  output logic [fhsa_pkg::CHAN_BITS-1:0]      pixel_blue_o,
  output logic [fhsa_pkg::HIT_BITS-1:0]       hit_count_o,
  output logic [fhsa_pkg::HIT_BITS-1:0]       peak_count_o,
  output logic                                in_range_o
);
  import fhsa_pkg::*;

  logic  busy, q_full, q_empty, q_push, q_pop;
  item_t push_item, pop_item;

  fhsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .busy_i        (busy),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  fhsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .empty_o     (q_empty)
  );

  fhsa_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .busy_o        (busy),
    .q_empty_i     (q_empty),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_red_o   (pixel_red_o),
    .pixel_green_o (pixel_green_o),
    .pixel_blue_o  (pixel_blue_o),
    .hit_count_o   (hit_count_o),
    .peak_count_o  (peak_count_o),
    .in_range_o    (in_range_o)
  );

endmodule
